// ----- rtl/vig_pkg.sv -----
`default_nettype none
package vig_pkg;

    localparam int KEY_DEPTH = 16;
    localparam int POS_W     = 4;
    localparam int SHIFT_W   = 5;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    localparam logic [5:0] ALPHABET = 6'd26;
    localparam logic [7:0] LOWER_A  = 8'd97;
    localparam logic [7:0] LOWER_Z  = 8'd122;
    localparam logic [7:0] UPPER_A  = 8'd65;
    localparam logic [7:0] UPPER_Z  = 8'd90;

    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_KEY  = 1'b1;

    localparam logic DIR_ENC = 1'b0;
    localparam logic DIR_DEC = 1'b1;

    localparam logic TBL_FIRST  = 1'b0;
    localparam logic TBL_SECOND = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYERS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LEN = 2'd3;

    typedef struct packed {
        logic             en;
        logic             tbl;
        logic [POS_W-1:0] slot;
        logic [7:0]       value;
    } t_key_wr;

    typedef struct packed {
        logic adv;
        logic letter;
        logic restart;
        logic layer2;
    } t_step;

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = ((c >= LOWER_A) && (c <= LOWER_Z)) || ((c >= UPPER_A) && (c <= UPPER_Z));
    endfunction

endpackage
`default_nettype wire

// ----- rtl/vig_req_if.sv -----
`default_nettype none
interface vig_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] char_in;
    logic       restart;
    logic       key_table;
    logic [3:0] key_slot;
    logic [7:0] key_value;

    modport source (output valid, req_type, char_in, restart, key_table, key_slot, key_value,
                    input ready);
    modport sink   (input valid, req_type, char_in, restart, key_table, key_slot, key_value,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/vig_rsp_if.sv -----
`default_nettype none
interface vig_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       was_letter;

    modport source (output valid, char_out, was_letter, input ready);
    modport sink   (input valid, char_out, was_letter, output ready);
endinterface
`default_nettype wire

// ----- rtl/two_layer_vigenere_shift_cipher_core.sv -----
// An accepted character passes the input register and then the vig_xform result register to o_rsp.
// Throughput: one item per cycle while o_rsp does not stall; key write items give no result.
// Backpressure on o_rsp holds a character in the input register and stops i_req.
// Reset (synchronous, active low) clears valids, key positions and config
// to direction 0, one layer, lengths 1; key tables stay undefined until written.
`default_nettype none
module two_layer_vigenere_shift_cipher_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [vig_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [vig_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    vig_req_if.sink                            i_req,
    vig_rsp_if.source                          o_rsp
);

    logic                        r_dir;
    logic [1:0]                  r_layers;
    logic [vig_pkg::LEN_W-1:0]   r_len1;
    logic [vig_pkg::LEN_W-1:0]   r_len2;

    logic                        r_s1_v;
    logic                        r_s1_type;
    logic [7:0]                  r_s1_char;
    logic                        r_s1_restart;
    logic                        r_s1_tbl;
    logic [vig_pkg::POS_W-1:0]   r_s1_slot;
    logic [7:0]                  r_s1_value;

    logic                        adv;
    logic                        take;
    logic                        letter;
    logic [vig_pkg::SHIFT_W-1:0] shift;
    vig_pkg::t_key_wr            key_wr;
    vig_pkg::t_step              step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir    <= vig_pkg::DIR_ENC;
            r_layers <= 2'd1;
            r_len1   <= vig_pkg::LEN_W'(1);
            r_len2   <= vig_pkg::LEN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vig_pkg::CFG_DIRECTION:  r_dir    <= i_cfg_data[0];
                vig_pkg::CFG_LAYERS:     r_layers <= i_cfg_data[1:0];
                vig_pkg::CFG_FIRST_LEN:  r_len1   <= i_cfg_data;
                vig_pkg::CFG_SECOND_LEN: r_len2   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance the input stage unless a character would overwrite a held result
    assign adv         = r_s1_v && ((r_s1_type == vig_pkg::REQ_KEY) || !o_rsp.valid || o_rsp.ready);
    assign i_req.ready = !r_s1_v || adv;
    assign take        = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (take) begin
            r_s1_v <= 1'b1;
        end else if (adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_type    <= i_req.req_type;
            r_s1_char    <= i_req.char_in;
            r_s1_restart <= i_req.restart;
            r_s1_tbl     <= i_req.key_table;
            r_s1_slot    <= i_req.key_slot;
            r_s1_value   <= i_req.key_value;
        end
    end

    always_comb begin
        key_wr.en     = adv && (r_s1_type == vig_pkg::REQ_KEY);
        key_wr.tbl    = r_s1_tbl;
        key_wr.slot   = r_s1_slot;
        key_wr.value  = r_s1_value;
        step.adv      = adv && (r_s1_type == vig_pkg::REQ_CHAR);
        step.letter   = letter;
        step.restart  = r_s1_restart;
        step.layer2   = r_layers[1];
    end

    vig_kstore u_kstore (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (key_wr),
        .i_step  (step),
        .i_len1  (r_len1),
        .i_len2  (r_len2),
        .o_shift (shift)
    );

    vig_xform u_xform (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step.adv),
        .i_char   (r_s1_char),
        .i_dir    (r_dir),
        .i_shift  (shift),
        .o_letter (letter),
        .o_rsp    (o_rsp)
    );

    a_char_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.adv |=> o_rsp.valid)
        else $error("character item left no result");

    a_letter_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.was_letter) |-> vig_pkg::is_letter(o_rsp.char_out))
        else $error("letter result is not a letter");

    a_nonletter_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.was_letter) |-> !vig_pkg::is_letter(o_rsp.char_out))
        else $error("non-letter result is a letter");

    a_take_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_s1_v)
        else $error("accepted item lost from input stage");

endmodule
`default_nettype wire

// ----- rtl/vig_kstore.sv -----
`default_nettype none
module vig_kstore (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  vig_pkg::t_key_wr             i_wr,
    input  vig_pkg::t_step               i_step,
    input  wire  [vig_pkg::LEN_W-1:0]    i_len1,
    input  wire  [vig_pkg::LEN_W-1:0]    i_len2,
    output logic [vig_pkg::SHIFT_W-1:0]  o_shift
);

    logic [vig_pkg::SHIFT_W-1:0] r_key1 [vig_pkg::KEY_DEPTH];
    logic [vig_pkg::SHIFT_W-1:0] r_key2 [vig_pkg::KEY_DEPTH];
    logic [vig_pkg::POS_W-1:0]   r_pos1;
    logic [vig_pkg::POS_W-1:0]   r_pos2;
    logic [vig_pkg::POS_W-1:0]   n_pos1;
    logic [vig_pkg::POS_W-1:0]   n_pos2;

    logic [vig_pkg::LEN_W-1:0]   len1_e;
    logic [vig_pkg::LEN_W-1:0]   len2_e;
    logic [vig_pkg::POS_W-1:0]   use1;
    logic [vig_pkg::POS_W-1:0]   use2;
    logic [vig_pkg::LEN_W-1:0]   inc1;
    logic [vig_pkg::LEN_W-1:0]   inc2;
    logic [vig_pkg::SHIFT_W-1:0] s1;
    logic [vig_pkg::SHIFT_W-1:0] s2;
    logic [5:0]                  sum;
    logic [vig_pkg::SHIFT_W-1:0] wr_mod;

    function automatic logic [vig_pkg::LEN_W-1:0] eff_len(input logic [vig_pkg::LEN_W-1:0] l);
        if (l == '0) begin
            eff_len = vig_pkg::LEN_W'(1);
        end else if (l > vig_pkg::LEN_W'(vig_pkg::KEY_DEPTH)) begin
            eff_len = vig_pkg::LEN_W'(vig_pkg::KEY_DEPTH);
        end else begin
            eff_len = l;
        end
    endfunction

    // value mod 26 through a reciprocal multiply, exact for 8-bit values
    function automatic logic [vig_pkg::SHIFT_W-1:0] mod26(input logic [7:0] v);
        logic [15:0] prod;
        logic [3:0]  q;
        logic [8:0]  r;
        prod = 16'(v) * 16'd158;
        q    = prod[15:12];
        r    = 9'(v) - 9'(q * 8'd26);
        if (r >= 9'(vig_pkg::ALPHABET)) begin
            r = r - 9'(vig_pkg::ALPHABET);
        end
        mod26 = r[vig_pkg::SHIFT_W-1:0];
    endfunction

    assign wr_mod = mod26(i_wr.value);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            if (i_wr.tbl == vig_pkg::TBL_FIRST) begin
                r_key1[i_wr.slot] <= wr_mod;
            end else begin
                r_key2[i_wr.slot] <= wr_mod;
            end
        end
    end

    always_comb begin
        len1_e = eff_len(i_len1);
        len2_e = eff_len(i_len2);
        use1   = (i_step.restart || ({1'b0, r_pos1} >= len1_e)) ? '0 : r_pos1;
        use2   = (i_step.restart || ({1'b0, r_pos2} >= len2_e)) ? '0 : r_pos2;
        inc1   = {1'b0, use1} + vig_pkg::LEN_W'(1);
        inc2   = {1'b0, use2} + vig_pkg::LEN_W'(1);
        s1     = r_key1[use1];
        s2     = i_step.layer2 ? r_key2[use2] : '0;
        sum    = 6'(s1) + 6'(s2);
        o_shift = (sum >= vig_pkg::ALPHABET) ? 5'(sum - vig_pkg::ALPHABET) : sum[4:0];

        n_pos1 = r_pos1;
        n_pos2 = r_pos2;
        if (i_step.adv && i_step.restart) begin
            n_pos1 = '0;
            n_pos2 = '0;
        end
        if (i_step.adv && i_step.letter) begin
            n_pos1 = (inc1 >= len1_e) ? '0 : inc1[vig_pkg::POS_W-1:0];
            if (i_step.layer2) begin
                n_pos2 = (inc2 >= len2_e) ? '0 : inc2[vig_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos1 <= '0;
            r_pos2 <= '0;
        end else begin
            r_pos1 <= n_pos1;
            r_pos2 <= n_pos2;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/vig_xform.sv -----
`default_nettype none
module vig_xform (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_load,
    input  wire  [7:0]                      i_char,
    input  wire                             i_dir,
    input  wire  [vig_pkg::SHIFT_W-1:0]     i_shift,
    output logic                            o_letter,
    vig_rsp_if.source                       o_rsp
);

    logic       lower;
    logic [7:0] base;
    logic [4:0] offset;
    logic [5:0] t;
    logic [4:0] rot;
    logic [7:0] n_char;

    logic       r_v;
    logic       n_v;
    logic [7:0] r_char;
    logic       r_letter;

    always_comb begin
        lower    = (i_char >= vig_pkg::LOWER_A) && (i_char <= vig_pkg::LOWER_Z);
        o_letter = vig_pkg::is_letter(i_char);
        base     = lower ? vig_pkg::LOWER_A : vig_pkg::UPPER_A;
        offset   = 5'(i_char - base);
        if (i_dir == vig_pkg::DIR_ENC) begin
            t = 6'(offset) + 6'(i_shift);
        end else begin
            t = 6'(offset) + vig_pkg::ALPHABET - 6'(i_shift);
        end
        rot    = (t >= vig_pkg::ALPHABET) ? 5'(t - vig_pkg::ALPHABET) : t[4:0];
        n_char = o_letter ? (base + 8'(rot)) : i_char;
        n_v    = i_load ? 1'b1 : (o_rsp.ready ? 1'b0 : r_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_char   <= n_char;
            r_letter <= o_letter;
        end
    end

    assign o_rsp.valid      = r_v;
    assign o_rsp.char_out   = r_char;
    assign o_rsp.was_letter = r_letter;

endmodule
`default_nettype wire

// ----- verif/two_layer_vigenere_shift_cipher_core_tb.sv -----
`default_nettype none
module two_layer_vigenere_shift_cipher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vig_pkg::*;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_in;
        logic       restart;
        logic       key_table;
        logic [3:0] key_slot;
        logic [7:0] key_value;
    } cipher_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       letter;
    } cipher_rsp_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    vig_req_if req_bus ();
    vig_rsp_if rsp_bus ();

    two_layer_vigenere_shift_cipher_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus)
    );

    int send_idle_pct = 6;
    int recv_idle_pct = 69;
    int mismatch_count = 0;

    logic       dir_reg = DIR_ENC;
    logic [1:0] layers_reg = 2'd1;
    logic [4:0] first_len_reg = 5'd1;
    logic [4:0] second_len_reg = 5'd1;
    logic [4:0] first_keys [KEY_DEPTH];
    logic [4:0] second_keys [KEY_DEPTH];
    int         first_pos = 0;
    int         second_pos = 0;

    cipher_rsp_t expected_chars [$];
    cipher_rsp_t want;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_chars.size() == 0) begin
                $error("char_out: expected none, got %0d", rsp_bus.char_out);
                mismatch_count++;
            end else begin
                want = expected_chars.pop_front();
                if (rsp_bus.char_out !== want.ch) begin
                    $error("char_out: expected %0d, got %0d", want.ch, rsp_bus.char_out);
                    mismatch_count++;
                end
                if (rsp_bus.was_letter !== want.letter) begin
                    $error("was_letter: expected %0d, got %0d", want.letter,
                           rsp_bus.was_letter);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic int next_key_shift(input logic second, input logic [4:0] len_raw);
        int len;
        int p;
        int s;
        len = (len_raw == 0) ? 1 : ((len_raw > KEY_DEPTH) ? KEY_DEPTH : int'(len_raw));
        p = second ? second_pos : first_pos;
        if (p >= len) p = 0;
        s = second ? int'(second_keys[p]) : int'(first_keys[p]);
        p++;
        if (p >= len) p = 0;
        if (second) second_pos = p;
        else first_pos = p;
        return s;
    endfunction

    function automatic void predict_cipher(input cipher_req_t item);
        int          base;
        int          shift;
        int          ofs;
        cipher_rsp_t res;
        if (item.req_type == REQ_KEY) begin
            if (item.key_table == TBL_FIRST) first_keys[item.key_slot] = 5'(item.key_value % 26);
            else second_keys[item.key_slot] = 5'(item.key_value % 26);
            return;
        end
        if (item.restart) begin
            first_pos  = 0;
            second_pos = 0;
        end
        res.ch     = item.char_in;
        res.letter = 1'b0;
        if (item.char_in >= LOWER_A && item.char_in <= LOWER_Z) base = int'(LOWER_A);
        else if (item.char_in >= UPPER_A && item.char_in <= UPPER_Z) base = int'(UPPER_A);
        else base = 0;
        if (base != 0) begin
            shift = next_key_shift(1'b0, first_len_reg);
            if (layers_reg >= 2) shift += next_key_shift(1'b1, second_len_reg);
            shift = shift % 26;
            ofs = int'(item.char_in) - base;
            if (dir_reg == DIR_ENC) ofs = (ofs + shift) % 26;
            else ofs = (ofs + 26 - shift) % 26;
            res.ch     = 8'(base + ofs);
            res.letter = 1'b1;
        end
        expected_chars.push_back(res);
    endfunction

    task automatic send_item(input cipher_req_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= item.req_type;
        req_bus.char_in   <= item.char_in;
        req_bus.restart   <= item.restart;
        req_bus.key_table <= item.key_table;
        req_bus.key_slot  <= item.key_slot;
        req_bus.key_value <= item.key_value;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        predict_cipher(item);
    endtask

    task automatic send_char(input logic [7:0] ch, input logic restart);
        cipher_req_t item;
        item.req_type  = REQ_CHAR;
        item.char_in   = ch;
        item.restart   = restart;
        item.key_table = 1'($urandom_range(1));
        item.key_slot  = 4'($urandom_range(15));
        item.key_value = 8'($urandom_range(255));
        send_item(item);
    endtask

    task automatic send_key(input logic which, input logic [3:0] slot, input logic [7:0] value);
        cipher_req_t item;
        item.req_type  = REQ_KEY;
        item.char_in   = 8'($urandom_range(255));
        item.restart   = 1'($urandom_range(1));
        item.key_table = which;
        item.key_slot  = slot;
        item.key_value = value;
        send_item(item);
    endtask

    function automatic logic [7:0] random_letter();
        if ($urandom_range(1) == 0) return 8'(LOWER_A + $urandom_range(25));
        return 8'(UPPER_A + $urandom_range(25));
    endfunction

    function automatic logic [7:0] random_byte();
        int r;
        r = $urandom_range(99);
        if (r < 70) return random_letter();
        if (r < 80) return 8'd32;
        return 8'($urandom_range(255));
    endfunction

    // hold until every result is back and any trailing key write has landed
    task automatic drain_block();
        req_bus.valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_DIRECTION: begin
                dir_reg = data[0];
            end
            CFG_LAYERS: begin
                layers_reg = data[1:0];
            end
            CFG_FIRST_LEN: begin
                first_len_reg = data;
            end
            default: begin
                second_len_reg = data;
            end
        endcase
    endtask

    task automatic configure(input logic dir, input logic [1:0] layers,
                             input logic [4:0] len1, input logic [4:0] len2);
        write_reg(CFG_DIRECTION, {4'($urandom_range(15)), dir});
        write_reg(CFG_LAYERS, {3'($urandom_range(7)), layers});
        write_reg(CFG_FIRST_LEN, len1);
        write_reg(CFG_SECOND_LEN, len2);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_key_load();
        int slot;
        int t;
        logic [7:0] value;
        for (slot = 0; slot < KEY_DEPTH; slot++) begin
            for (t = 0; t < 2; t++) begin
                case (slot)
                    0: begin
                        value = 8'd255;
                    end
                    1: begin
                        value = 8'd0;
                    end
                    2: begin
                        value = 8'd25;
                    end
                    3: begin
                        value = 8'd26;
                    end
                    default: begin
                        value = 8'($urandom_range(255));
                    end
                endcase
                send_key(t == 1 ? TBL_SECOND : TBL_FIRST, 4'(slot), value);
            end
        end
    endtask

    task automatic test_passthrough();
        logic [7:0] edges [13];
        int k;
        edges = '{8'd0, 8'd32, 8'd64, 8'd65, 8'd90, 8'd91, 8'd96, 8'd97,
                  8'd122, 8'd123, 8'd127, 8'd128, 8'd255};
        drain_block();
        for (k = 0; k < 13; k++) send_char(edges[k], k == 0);
    endtask

    task automatic test_register_extremes();
        int k;
        drain_block();
        configure(DIR_DEC, 2'd0, 5'd0, 5'd0);
        send_char(8'd65, 1'b1);
        send_char(8'd122, 1'b0);
        drain_block();
        configure(DIR_ENC, 2'd3, 5'd31, 5'd16);
        for (k = 0; k < 18; k++) send_char(random_letter(), k == 0);
        drain_block();
        configure(DIR_DEC, 2'd2, 5'd16, 5'd1);
        for (k = 0; k < 5; k++) send_char(random_letter(), k == 0);
    endtask

    task automatic test_position_shrink();
        int k;
        drain_block();
        configure(DIR_ENC, 2'd2, 5'd16, 5'd16);
        for (k = 0; k < 10; k++) send_char(random_letter(), k == 0);
        drain_block();
        configure(DIR_DEC, 2'd2, 5'd3, 5'd5);
        for (k = 0; k < 4; k++) send_char(random_letter(), 1'b0);
        drain_block();
        configure(DIR_ENC, 2'd1, 5'd7, 5'd5);
        for (k = 0; k < 3; k++) send_char(random_letter(), 1'b0);
        drain_block();
        configure(DIR_ENC, 2'd2, 5'd7, 5'd5);
        for (k = 0; k < 3; k++) send_char(random_letter(), 1'b0);
    endtask

    task automatic test_random_traffic(input int phases, input int per_phase);
        int sent;
        int msg_len;
        int k;
        logic [4:0] len1;
        logic [4:0] len2;
        repeat (phases) begin
            drain_block();
            len1 = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 16));
            len2 = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 16));
            configure(1'($urandom_range(1)), 2'($urandom_range(3)), len1, len2);
            sent = 0;
            while (sent < per_phase) begin
                msg_len = $urandom_range(1, 24);
                for (k = 0; k < msg_len; k++) begin
                    if ($urandom_range(99) < 5) begin
                        send_key(1'($urandom_range(1)), 4'($urandom_range(15)),
                                 8'($urandom_range(255)));
                    end else begin
                        send_char(random_byte(), (k == 0) || ($urandom_range(99) == 0));
                    end
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_DIRECTION;
        i_cfg_data        <= '0;
        req_bus.valid     <= 1'b0;
        req_bus.req_type  <= REQ_CHAR;
        req_bus.char_in   <= 8'd0;
        req_bus.restart   <= 1'b0;
        req_bus.key_table <= TBL_FIRST;
        req_bus.key_slot  <= 4'd0;
        req_bus.key_value <= 8'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_key_load();
        test_passthrough();
        test_register_extremes();
        test_position_shrink();
        test_random_traffic(3, 110);

        drain_block();
        send_idle_pct = 69;
        recv_idle_pct = 6;
        test_random_traffic(3, 110);

        drain_block();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(3, 110);

        drain_block();
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/vig_pkg.sv
rtl/vig_req_if.sv
rtl/vig_rsp_if.sv
rtl/vig_kstore.sv
rtl/vig_xform.sv
rtl/two_layer_vigenere_shift_cipher_core.sv
verif/two_layer_vigenere_shift_cipher_core_tb.sv
